// File: rtl/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types and constants of the graphics coordinate re-encoder.
// ----------------------------------------------------------------------------
package gcr_pkg;

  // Drawing commands.
  localparam logic [2:0] CMD_PT_DELTA = 3'd0;
  localparam logic [2:0] CMD_PT_ABS   = 3'd1;
  localparam logic [2:0] CMD_SEGMENT  = 3'd2;
  localparam logic [2:0] CMD_RECT     = 3'd3;
  localparam logic [2:0] CMD_ARC      = 3'd4;

  // A record is coded as up to six values, each of one or two bytes.
  localparam int NTOK_MAX = 6;
  localparam logic [2:0] NTOK_POINT = 3'd2;
  localparam logic [2:0] NTOK_SEG   = 3'd4;
  localparam logic [2:0] NTOK_ARC   = 3'd6;

  // Depth of the queue between the classifier and the serialiser.
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Coding limits.
  localparam logic signed [15:0] SHORT_TWO_NEG = -16'sd113;
  localparam logic signed [15:0] SHORT_TWO_POS = 16'sd128;
  localparam logic [15:0]        USHORT_LIMIT  = 16'h1000;
  localparam logic [15:0]        USHORT_TWO    = 16'd240;
  localparam logic signed [15:0] ANGLE_MAX     = 16'sd23040;
  localparam logic signed [15:0] ANGLE_MIN     = -16'sd23040;
  localparam int                 ANGLE_STEP    = 45 * 128;
  localparam int                 ANGLE_CODES   = 9;

  // One coded value.
  typedef struct packed {
    logic       ok;
    logic       two;
    logic [7:0] hi;
    logic [7:0] lo;
  } enc_t;

  // One classified record as it waits in the queue.
  typedef struct packed {
    logic                         err;
    logic [2:0]                   ntok;
    logic [NTOK_MAX-1:0]          two;
    logic [NTOK_MAX-1:0][7:0]     hi;
    logic [NTOK_MAX-1:0][7:0]     lo;
  } rec_t;

endpackage

// File: rtl/gcr_front.sv
// ----------------------------------------------------------------------------
// gcr_front
// Accepts drawing records, codes every value in parallel, tracks the
// previous origin and the error flag, and queues records of used commands.
// ----------------------------------------------------------------------------
module gcr_front import gcr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic               in_start_req,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_angle_start,
  input  logic signed [15:0] in_angle_extent,
  input  logic               q_full,
  output logic               q_push,
  output rec_t               q_data
);

  function automatic enc_t enc_short(input logic [15:0] v);
    enc_t e;
    e.ok  = (v[15:11] == 5'b00000) || (v[15:11] == 5'b11111);
    e.two = ($signed(v) <= SHORT_TWO_NEG) || ($signed(v) >= SHORT_TWO_POS);
    e.hi  = {4'h8, v[11:8]};
    e.lo  = v[7:0];
    return e;
  endfunction

  function automatic enc_t enc_ushort(input logic [15:0] v);
    enc_t e;
    e.ok  = v < USHORT_LIMIT;
    e.two = v >= USHORT_TWO;
    e.hi  = {4'hf, v[11:8]};
    e.lo  = v[7:0];
    return e;
  endfunction

  // Whole multiples of 45 degrees take a single byte holding the multiple
  // offset by four.
  function automatic enc_t enc_angle(input logic [15:0] v);
    enc_t e;
    e.ok  = ($signed(v) >= ANGLE_MIN) && ($signed(v) <= ANGLE_MAX);
    e.two = 1'b1;
    e.hi  = v[15:8];
    e.lo  = v[7:0];
    for (int k = 0; k < ANGLE_CODES; k++) begin
      if (v == 16'((k - 4) * ANGLE_STEP)) begin
        e.two = 1'b0;
        e.lo  = 8'h80 | 8'(k);
      end
    end
    return e;
  endfunction

  logic [15:0] prev_x_r, prev_x_nxt;
  logic [15:0] prev_y_r, prev_y_nxt;
  logic        failed_r, failed_nxt;

  logic [15:0] base_x, base_y;
  logic        base_failed;
  logic        accept;
  logic        cmd_ok;
  logic        fault;
  enc_t        tok [NTOK_MAX];
  logic [2:0]  ntok;
  rec_t        rec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cmd_ok   = in_command <= CMD_ARC;

  // A request start clears the origin and the error before the record.
  assign base_x      = in_start_req ? 16'd0 : prev_x_r;
  assign base_y      = in_start_req ? 16'd0 : prev_y_r;
  assign base_failed = in_start_req ? 1'b0 : failed_r;

  always_comb begin
    if (in_command == CMD_PT_ABS) begin
      tok[0] = enc_short(in_first_x);
      tok[1] = enc_short(in_first_y);
    end else begin
      tok[0] = enc_short(16'(in_first_x - base_x));
      tok[1] = enc_short(16'(in_first_y - base_y));
    end
    if (in_command == CMD_SEGMENT) begin
      tok[2] = enc_short(16'(in_second_x - in_first_x));
      tok[3] = enc_short(16'(in_second_y - in_first_y));
    end else begin
      tok[2] = enc_ushort(in_second_x);
      tok[3] = enc_ushort(in_second_y);
    end
    tok[4] = enc_angle(in_angle_start);
    tok[5] = enc_angle(in_angle_extent);
  end

  always_comb begin
    unique case (in_command)
      CMD_PT_DELTA, CMD_PT_ABS: ntok = NTOK_POINT;
      CMD_SEGMENT, CMD_RECT:    ntok = NTOK_SEG;
      default:                  ntok = NTOK_ARC;
    endcase
  end

  always_comb begin
    fault = !tok[0].ok || !tok[1].ok;
    if (ntok != NTOK_POINT) begin
      fault = fault || !tok[2].ok || !tok[3].ok;
    end
    if (ntok == NTOK_ARC) begin
      fault = fault || !tok[4].ok || !tok[5].ok;
    end
  end

  always_comb begin
    rec.err  = base_failed || fault;
    rec.ntok = ntok;
    for (int i = 0; i < NTOK_MAX; i++) begin
      rec.two[i] = tok[i].two;
      rec.hi[i]  = tok[i].hi;
      rec.lo[i]  = tok[i].lo;
    end
    // An error record is a single zero byte.
    if (rec.err) begin
      rec.ntok  = 3'd1;
      rec.two   = '0;
      rec.lo[0] = 8'h00;
    end
  end

  assign q_push = accept && cmd_ok;
  assign q_data = rec;

  always_comb begin
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    failed_nxt = failed_r;
    if (accept) begin
      prev_x_nxt = base_x;
      prev_y_nxt = base_y;
      failed_nxt = base_failed;
      if (cmd_ok && !base_failed) begin
        if (fault) begin
          failed_nxt = 1'b1;
        end else if (in_command != CMD_PT_ABS) begin
          prev_x_nxt = in_first_x;
          prev_y_nxt = in_first_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      failed_r <= 1'b0;
    end else begin
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// File: rtl/gcr_queue.sv
// ----------------------------------------------------------------------------
// gcr_queue
// Short first-in first-out queue of classified records.
// ----------------------------------------------------------------------------
module gcr_queue import gcr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output rec_t head
);

  rec_t            mem_r [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign full       = count_r == Q_CW'(Q_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("record pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("record popped from an empty queue");

endmodule

// File: rtl/gcr_back.sv
// ----------------------------------------------------------------------------
// gcr_back
// Walks the record at the head of the queue and sends one code byte per
// cycle through the output register while the receiver is ready.
// ----------------------------------------------------------------------------
module gcr_back import gcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  rec_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code_byte,
  output logic       out_last,
  output logic       out_error
);

  logic [2:0] tok_r, tok_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_err_r;

  logic       advance;
  logic       high_byte;
  logic       is_last;
  logic [7:0] sel_byte;

  assign advance   = !out_valid_r || out_ready;
  // The first byte of a two-byte value is its high part.
  assign high_byte = head.two[tok_r] && !phase_r;
  assign sel_byte  = high_byte ? head.hi[tok_r] : head.lo[tok_r];
  assign is_last   = (tok_r == head.ntok - 3'd1) && !high_byte;
  assign pop       = advance && head_valid && is_last;

  always_comb begin
    tok_nxt       = tok_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        if (high_byte) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          tok_nxt   = is_last ? 3'd0 : tok_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tok_r       <= tok_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      out_byte_r <= sel_byte;
      out_last_r <= is_last;
      out_err_r  <= head.err;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code_byte = out_byte_r;
  assign out_last      = out_last_r;
  assign out_error     = out_err_r;

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r && (out_byte_r == 8'h00))
    else $error("error item is not a single zero byte");

  a_tok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (tok_r < head.ntok))
    else $error("value index beyond the record");

  a_phase_two: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && phase_r |-> head.two[tok_r])
    else $error("low byte phase on a one-byte value");

endmodule

// File: rtl/graphics_coordinate_reencoder.sv
// ----------------------------------------------------------------------------
// graphics_coordinate_reencoder
// Codes drawing records (points, segments, rectangles, arcs) into a
// variable-length byte stream with delta-coded coordinates.
//
// Input channel: one drawing record per item (in_valid / in_ready). A record
// with start_req set clears the previous origin and the error flag first.
// Output channel: one code byte per item (out_valid / out_ready), with
// out_last on the final byte of a record and out_error on the single zero
// byte that replaces a record once a value has gone out of range. Commands
// five to seven produce no bytes.
// When the queue is empty, an accepted record is written into the queue and its
// first byte then goes out through the output register of the serialiser.
// Throughput: while the receiver is ready, the serialiser sends one byte per
// cycle; a record has one to twelve bytes, and records follow each other with
// no gap. The classifier takes one record per cycle while the two-entry record
// queue has room.
// Reset: synchronous and active low; it empties the queue, drops out_valid
// and clears the origin and the error flag.
// A stalled receiver holds the current byte; the queue fills and in_ready
// falls once it holds two records, counting the one whose bytes are still
// being sent.
// ----------------------------------------------------------------------------
module graphics_coordinate_reencoder import gcr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic               in_start_req,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_angle_start,
  input  logic signed [15:0] in_angle_extent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_code_byte,
  output logic               out_last,
  output logic               out_error
);

  logic q_full;
  logic q_push;
  rec_t q_data;
  logic q_pop;
  logic q_valid;
  rec_t q_head;

  gcr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_start_req    (in_start_req),
    .in_first_x      (in_first_x),
    .in_first_y      (in_first_y),
    .in_second_x     (in_second_x),
    .in_second_y     (in_second_y),
    .in_angle_start  (in_angle_start),
    .in_angle_extent (in_angle_extent),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  gcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  gcr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_valid),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_byte (out_code_byte),
    .out_last      (out_last),
    .out_error     (out_error)
  );

endmodule

// File: tb/graphics_coordinate_reencoder_test.sv
// ----------------------------------------------------------------------------
// graphics_coordinate_reencoder_test
// Drives drawing records into the re-encoder and checks every code byte that
// comes out against a byte-code predictor that keeps its own origin and error
// flag. A directed opening covers the coding limits, every command and the
// error cases. Random requests follow, with bursty input, a receiver that
// stalls in changing patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module graphics_coordinate_reencoder_test import gcr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_TOP = 3'd7;  // highest command code the port can carry
  localparam int SHORT_MAX      = 2047;
  localparam int SHORT_MIN      = -2048;
  localparam int ANGLE_BIAS     = ANGLE_CODES / 2;
  localparam int RANDOM_RECORDS = 420;
  localparam int HOLD_AFTER     = 100;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [2:0]         command;
    logic               start_req;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] angle_start;
    logic signed [15:0] angle_extent;
  } draw_rec_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       err;
  } code_item_t;

  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_EVERY_THIRD} rx_mode_t;

  // Predicts the code bytes of each accepted record and checks the output
  // stream against them in order.
  class code_stream_checker;
    logic [15:0] prev_x = '0;
    logic [15:0] prev_y = '0;
    bit          failed = 1'b0;
    code_item_t  expected_bytes[$];
    logic [7:0]  record_bytes[$];
    int          mismatches = 0;

    function int wrap_delta(logic [15:0] a, logic [15:0] b);
      logic signed [15:0] d;
      d = a - b;
      return int'(d);
    endfunction

    function bit put_short(int v);
      if (v > SHORT_MAX || v < SHORT_MIN) return 1'b0;
      if (v <= SHORT_TWO_NEG || v >= SHORT_TWO_POS) record_bytes.push_back({4'h8, v[11:8]});
      record_bytes.push_back(v[7:0]);
      return 1'b1;
    endfunction

    function bit put_ushort(logic [15:0] u);
      if (u >= USHORT_LIMIT) return 1'b0;
      if (u >= USHORT_TWO) record_bytes.push_back({4'hf, u[11:8]});
      record_bytes.push_back(u[7:0]);
      return 1'b1;
    endfunction

    function bit put_angle(logic signed [15:0] v);
      if (v < ANGLE_MIN || v > ANGLE_MAX) return 1'b0;
      // Whole multiples of 45 degrees collapse to a single index byte.
      if (int'(v) % ANGLE_STEP == 0) begin
        record_bytes.push_back(8'h80 | 8'(int'(v) / ANGLE_STEP + ANGLE_BIAS));
      end else begin
        record_bytes.push_back(v[15:8]);
        record_bytes.push_back(v[7:0]);
      end
      return 1'b1;
    endfunction

    function void note_record(draw_rec_t r);
      logic [15:0] nx;
      logic [15:0] ny;
      bit ok;
      nx = prev_x;
      ny = prev_y;
      ok = 1'b1;
      record_bytes.delete();
      if (r.start_req) begin
        prev_x = '0;
        prev_y = '0;
        failed = 1'b0;
        nx = '0;
        ny = '0;
      end
      if (r.command > CMD_ARC) return;
      if (!failed) begin
        if (r.command == CMD_PT_ABS) begin
          ok = put_short(int'(r.first_x));
          if (ok) ok = put_short(int'(r.first_y));
        end else begin
          ok = put_short(wrap_delta(r.first_x, prev_x));
          if (ok) ok = put_short(wrap_delta(r.first_y, prev_y));
          nx = r.first_x;
          ny = r.first_y;
          if (ok && r.command == CMD_SEGMENT) begin
            ok = put_short(wrap_delta(r.second_x, nx));
            if (ok) ok = put_short(wrap_delta(r.second_y, ny));
          end
          if (ok && (r.command == CMD_RECT || r.command == CMD_ARC)) begin
            ok = put_ushort(r.second_x);
            if (ok) ok = put_ushort(r.second_y);
          end
          if (ok && r.command == CMD_ARC) begin
            ok = put_angle(r.angle_start);
            if (ok) ok = put_angle(r.angle_extent);
          end
        end
        if (!ok) failed = 1'b1;
      end
      // Once failed, each used-command record gets one zero byte; the origin is kept.
      if (failed) begin
        expected_bytes.push_back('{code: 8'h00, last: 1'b1, err: 1'b1});
        return;
      end
      prev_x = nx;
      prev_y = ny;
      foreach (record_bytes[i])
        expected_bytes.push_back('{code: record_bytes[i],
                                   last: (i == record_bytes.size() - 1), err: 1'b0});
    endfunction

    function void check_byte(logic [7:0] code, logic last, logic err);
      code_item_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: code_byte %02h last %0b error %0b", code, last, err);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (code !== want.code) begin
        $error("code_byte: expected %02h, actual %02h", want.code, code);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
      if (err !== want.err) begin
        $error("error: expected %0b, actual %0b", want.err, err);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  draw_rec_t  drive_rec;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_code_byte;
  logic       out_last;
  logic       out_error;

  code_stream_checker sb;
  logic signed [15:0] gen_x;
  logic signed [15:0] gen_y;
  int  burst_left = 0;
  bit  hold_due = 1'b0;
  bit  hold_done = 1'b0;

  always #5 clk = ~clk;

  graphics_coordinate_reencoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (drive_rec.command),
    .in_start_req   (drive_rec.start_req),
    .in_first_x     (drive_rec.first_x),
    .in_first_y     (drive_rec.first_y),
    .in_second_x    (drive_rec.second_x),
    .in_second_y    (drive_rec.second_y),
    .in_angle_start (drive_rec.angle_start),
    .in_angle_extent(drive_rec.angle_extent),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_byte  (out_code_byte),
    .out_last       (out_last),
    .out_error      (out_error)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_record(drive_rec);
      if (out_valid && out_ready) sb.check_byte(out_code_byte, out_last, out_error);
    end
  end

  function automatic draw_rec_t rec_of(logic [2:0] cmd, logic start, int fx, int fy,
                                       int sx, int sy, int as, int ae);
    draw_rec_t r;
    r.command      = cmd;
    r.start_req    = start;
    r.first_x      = 16'(fx);
    r.first_y      = 16'(fy);
    r.second_x     = 16'(sx);
    r.second_y     = 16'(sy);
    r.angle_start  = 16'(as);
    r.angle_extent = 16'(ae);
    return r;
  endfunction

  function automatic int short_offset();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick < 26) return int'($urandom_range(0, 239)) - 112;
    if (pick < 36) return int'($urandom_range(0, 4095)) - 2048;
    if (pick < 39) begin
      case ($urandom_range(0, 5))
        0: return -2048;
        1: return 2047;
        2: return -113;
        3: return -112;
        4: return 127;
        default: return 128;
      endcase
    end
    return $urandom_range(0, 1) ? int'($urandom_range(2048, 30000))
                                : -int'($urandom_range(2049, 30000));
  endfunction

  function automatic int ushort_value();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick < 26) return $urandom_range(0, 239);
    if (pick < 36) return $urandom_range(240, 4095);
    if (pick < 39) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return 239;
        2: return 240;
        default: return 4095;
      endcase
    end
    return $urandom_range(4096, 65535);
  endfunction

  function automatic int angle_value();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick < 14) return (int'($urandom_range(0, ANGLE_CODES - 1)) - ANGLE_BIAS) * ANGLE_STEP;
    if (pick < 34) return int'($urandom_range(0, 2 * ANGLE_MAX)) + ANGLE_MIN;
    if (pick < 39) begin
      case ($urandom_range(0, 3))
        0: return int'(ANGLE_MIN);
        1: return int'(ANGLE_MAX);
        2: return 128;
        default: return ANGLE_MAX - 1;
      endcase
    end
    return $urandom_range(0, 65535);
  endfunction

  // Builds one random record, mostly in range and relative to the origin the
  // block should hold; a drifting request steps x near the limit of a delta.
  function automatic draw_rec_t make_record(bit first, bit drift, bit drift_up);
    draw_rec_t r;
    int step_x;
    r.start_req = first || ($urandom_range(0, 31) == 0);
    if (r.start_req) begin
      gen_x = '0;
      gen_y = '0;
    end
    if ($urandom_range(0, 19) == 0) begin
      r.command      = 3'($urandom_range(CMD_TOP, CMD_PT_DELTA));
      r.first_x      = 16'($urandom());
      r.first_y      = 16'($urandom());
      r.second_x     = 16'($urandom());
      r.second_y     = 16'($urandom());
      r.angle_start  = 16'($urandom());
      r.angle_extent = 16'($urandom());
      if (r.command <= CMD_ARC && r.command != CMD_PT_ABS) begin
        gen_x = r.first_x;
        gen_y = r.first_y;
      end
      return r;
    end
    r.command = 3'($urandom_range(CMD_ARC, CMD_PT_DELTA));
    if (drift) step_x = drift_up ? int'($urandom_range(1800, 2047))
                                 : -int'($urandom_range(1800, 2048));
    else step_x = short_offset();
    if (r.command == CMD_PT_ABS) begin
      r.first_x = 16'(short_offset());
      r.first_y = 16'(short_offset());
    end else begin
      r.first_x = 16'(int'(gen_x) + step_x);
      r.first_y = 16'(int'(gen_y) + short_offset());
      gen_x = r.first_x;
      gen_y = r.first_y;
    end
    if (r.command == CMD_SEGMENT) begin
      r.second_x = 16'(int'(r.first_x) + short_offset());
      r.second_y = 16'(int'(r.first_y) + short_offset());
    end else begin
      r.second_x = 16'(ushort_value());
      r.second_y = 16'(ushort_value());
    end
    r.angle_start  = 16'(angle_value());
    r.angle_extent = 16'(angle_value());
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_record(draw_rec_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    drive_rec <= r;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int       mode_left;
    int       phase;
    int       held;
    rx_mode_t mode;
    mode = RX_ALWAYS;
    mode_left = 100;
    phase = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_due && !hold_done) begin
        // Long hold-off: the record queue fills and the input must stall.
        out_ready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          RX_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (phase % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    int random_count;
    int req_len;
    bit drift;
    bit drift_up;
    draw_rec_t r;
    sb = new;
    rst_n = 1'b0;
    in_valid = 1'b0;
    drive_rec = '0;
    gen_x = '0;
    gen_y = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Coding limits of deltas, absolute points, sizes and angles.
    send_record(rec_of(CMD_PT_DELTA, 1'b1, 0, 0, 0, 0, 0, 0));
    send_record(rec_of(CMD_PT_DELTA, 1'b0, 127, 15, 0, 0, 0, 0));
    send_record(rec_of(CMD_PT_DELTA, 1'b0, 255, -98, 0, 0, 0, 0));
    send_record(rec_of(CMD_PT_DELTA, 1'b0, 143, -210, 0, 0, 0, 0));
    send_record(rec_of(CMD_PT_ABS, 1'b0, 2047, -2048, 0, 0, 0, 0));
    send_record(rec_of(CMD_PT_ABS, 1'b0, -112, 127, 0, 0, 0, 0));
    send_record(rec_of(CMD_SEGMENT, 1'b0, 2190, -2258, 142, -211, 0, 0));
    send_record(rec_of(CMD_RECT, 1'b0, 2190, -2258, 239, 240, 0, 0));
    send_record(rec_of(CMD_RECT, 1'b0, 2190, -2258, 0, 4095, 0, 0));
    send_record(rec_of(CMD_ARC, 1'b0, 2190, -2258, 10, 300, 0, int'(ANGLE_MAX)));
    send_record(rec_of(CMD_ARC, 1'b0, 2190, -2258, 5, 5, int'(ANGLE_MIN), ANGLE_STEP));
    send_record(rec_of(CMD_ARC, 1'b0, 2190, -2258, 5, 5, 128, 100));
    send_record(rec_of(CMD_ARC, 1'b0, 2190, -2258, 5, 5, -3 * ANGLE_STEP, ANGLE_MAX - 1));
    // Unused commands, range faults and the sticky error.
    send_record(rec_of(CMD_ARC + 3'd1, 1'b0, 0, 0, 0, 0, 0, 0));
    send_record(rec_of(CMD_PT_ABS, 1'b0, 2048, 0, 0, 0, 0, 0));
    send_record(rec_of(CMD_SEGMENT, 1'b0, 0, 0, 0, 0, 0, 0));
    send_record(rec_of(CMD_TOP, 1'b0, 0, 0, 0, 0, 0, 0));
    send_record(rec_of(CMD_TOP - 3'd1, 1'b1, 0, 0, 0, 0, 0, 0));
    send_record(rec_of(CMD_PT_DELTA, 1'b0, 0, 0, 0, 0, 0, 0));
    send_record(rec_of(CMD_RECT, 1'b0, 0, 0, 4096, 0, 0, 0));
    send_record(rec_of(CMD_ARC, 1'b1, 0, 0, 5, 5, ANGLE_MAX + 1, 0));
    send_record(rec_of(CMD_PT_DELTA, 1'b1, -2049, 0, 0, 0, 0, 0));
    send_record(rec_of(CMD_SEGMENT, 1'b1, 100, 100, 2148, 100, 0, 0));
    send_record(rec_of(CMD_ARC, 1'b1, 0, 0, 0, 0, int'(ANGLE_MIN), 0));

    random_count = 0;
    while (random_count < RANDOM_RECORDS) begin
      req_len  = $urandom_range(1, 12);
      drift    = ($urandom_range(0, 7) == 0);
      drift_up = 1'($urandom_range(0, 1));
      for (int i = 0; i < req_len; i++) begin
        r = make_record(i == 0, drift, drift_up);
        if (r.command <= CMD_ARC) random_count++;
        if (random_count == HOLD_AFTER) hold_due = 1'b1;
        send_record(r);
      end
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
